>>> design/bqc_pkg.sv
// Shared types, constants and helpers for the two-section biquad cascade.
// No dependencies; every other design file uses this package.
`timescale 1ns / 1ps
`default_nettype none

package bqc_pkg;

	// Default sizes of the sample and coefficient formats
	localparam int SAMPLE_WIDTH_DEF   = 24;
	localparam int COEF_FRAC_BITS_DEF = 22;

	// Configuration register index width
	localparam int CFG_IDX_W = 3;

	// Coefficient register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_B0  = 3'd0,
		REG_FIRST_B1  = 3'd1,
		REG_FIRST_A1  = 3'd2,
		REG_FIRST_A2  = 3'd3,
		REG_SECOND_B0 = 3'd4,
		REG_SECOND_B1 = 3'd5,
		REG_SECOND_A1 = 3'd6,
		REG_SECOND_A2 = 3'd7
	} reg_idx_t;

	// Radix-4 Booth digit: which multiple of the multiplicand to add
	typedef enum logic [2:0] {
		BOOTH_ZERO,
		BOOTH_P1,
		BOOTH_P2,
		BOOTH_M1,
		BOOTH_M2
	} booth_op_t;

	// Control of one multiplier lane
	typedef struct packed {
		logic load;
		logic step;
	} lane_ctrl_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MULX,
		ST_ACC,
		ST_RND,
		ST_MULY,
		ST_UPD1,
		ST_UPD2,
		ST_DONE
	} state_t;

	// Booth recoding of the window {bit 2i+1, bit 2i, bit 2i-1}
	function automatic booth_op_t booth_decode(input logic [2:0] win);
		booth_op_t op;
		case (win)
			3'b001, 3'b010: op = BOOTH_P1;
			3'b011:         op = BOOTH_P2;
			3'b100:         op = BOOTH_M2;
			3'b101, 3'b110: op = BOOTH_M1;
			default:        op = BOOTH_ZERO;
		endcase
		return op;
	endfunction

endpackage

`default_nettype wire

>>> design/bqc_digit_sreg.sv
// Multiplier operand shift register: shifts two bits per step cycle and
// produces the radix-4 Booth digit for the multiplier lanes. Uses bqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bqc_digit_sreg #(
	parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    load,
	input  logic                    step,
	input  logic [SAMPLE_WIDTH-1:0] x_in,
	output bqc_pkg::booth_op_t      op
);
	import bqc_pkg::*;

	localparam int NDIG = (SAMPLE_WIDTH + 1) / 2;
	localparam int XW   = 2 * NDIG;

	logic [XW-1:0] sh_q;
	logic          prev_q;
	logic [XW-1:0] x_ext;

	// Sign-extend the operand to a whole number of digits
	assign x_ext = XW'($signed(x_in));

	// Load, then arithmetic shift right by one digit per step
	always_ff @(posedge clk) begin
		if (load) begin
			sh_q   <= x_ext;
			prev_q <= 1'b0;
		end else if (step) begin
			sh_q   <= {{2{sh_q[XW-1]}}, sh_q[XW-1:2]};
			prev_q <= sh_q[1];
		end
	end

	// Current Booth digit
	assign op = booth_decode({sh_q[1], sh_q[0], prev_q});

endmodule

`default_nettype wire

>>> design/bqc_booth_lane.sv
// One digit-serial multiplier lane: coefficient times a Booth-coded operand,
// one radix-4 digit per step cycle, product modulo the delay width. Uses bqc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bqc_booth_lane #(
	parameter int SAMPLE_WIDTH   = bqc_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_BITS_DEF,
	localparam int COEF_W        = COEF_FRAC_BITS + 2,
	localparam int DELAY_W       = SAMPLE_WIDTH + COEF_W
) (
	input  logic                 clk,
	input  bqc_pkg::lane_ctrl_t  ctrl,
	input  bqc_pkg::booth_op_t   op,
	input  logic [COEF_W-1:0]    coef,
	output logic [DELAY_W-1:0]   prod
);
	import bqc_pkg::*;

	logic [DELAY_W-1:0] mc_q;
	logic [DELAY_W-1:0] acc_q;
	logic [DELAY_W-1:0] term;

	// Partial product selected by the digit
	always_comb begin
		case (op)
			BOOTH_P1: term = mc_q;
			BOOTH_P2: term = {mc_q[DELAY_W-2:0], 1'b0};
			BOOTH_M1: term = ~mc_q + DELAY_W'(1);
			BOOTH_M2: term = ~{mc_q[DELAY_W-2:0], 1'b0} + DELAY_W'(1);
			default:  term = '0;
		endcase
	end

	// Accumulate and move the multiplicand up one digit
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= '0;
			mc_q  <= DELAY_W'($signed(coef));
		end else if (ctrl.step) begin
			acc_q <= acc_q + term;
			mc_q  <= {mc_q[DELAY_W-3:0], 2'b00};
		end
	end

	assign prod = acc_q;

endmodule

`default_nettype wire

>>> design/two_section_biquad_cascade_core.sv
// Two cascaded biquad sections (transposed direct form II, b2 = b0) with a
// digit-serial datapath. Depends on bqc_pkg, bqc_digit_sreg, bqc_booth_lane.
//
// Usage:
//   s_axis: one signed sample per beat in tdata. m_axis: one filtered,
//   saturated sample per beat in tdata, with the clip flag in tuser.
//   cfg: coefficient writes (index 0..7, Q2.COEF_FRAC_BITS data), always
//   ready; write only while no sample is in flight.
// Sequence:
//   With NDIG = ceil(SAMPLE_WIDTH/2) radix-4 digits, each section makes
//   two passes of the Booth lanes (b0*x with b1*x, then a1*y with a2*y)
//   plus four add/saturate steps. A new sample is taken only in the idle
//   state, after the previous result has moved to the output register.
// Reset:
//   Delay registers clear, coefficients reset to b0 = 1.0 and zero elsewhere,
//   output holds no beat.
// Stall:
//   The result sits in an output register; the next sample is taken and
//   processed meanwhile, and waits in its last step until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module two_section_biquad_cascade_core #(
	parameter int SAMPLE_WIDTH   = bqc_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_FRAC_BITS = bqc_pkg::COEF_FRAC_BITS_DEF,
	localparam int COEF_W        = COEF_FRAC_BITS + 2,
	localparam int TDATA_W       = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// input samples; tdata: sample_in
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [TDATA_W-1:0]            s_axis_tdata,
	// results; tdata: sample_out; tuser: clipped
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [TDATA_W-1:0]            m_axis_tdata,
	output logic                          m_axis_tuser,
	// coefficient writes
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bqc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]             cfg_data
);
	import bqc_pkg::*;

	localparam int NDIG    = (SAMPLE_WIDTH + 1) / 2;
	localparam int CNT_W   = $clog2(NDIG);
	localparam int DELAY_W = SAMPLE_WIDTH + COEF_W;
	localparam int SHW     = DELAY_W - COEF_FRAC_BITS;

	localparam logic [DELAY_W-1:0] D_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
	localparam logic [DELAY_W-1:0] D_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
	localparam logic [DELAY_W-1:0] HALF  =
		{{(DELAY_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
	localparam logic [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic [SAMPLE_WIDTH-1:0] Y_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam logic [COEF_W-1:0] COEF_ONE =
		{2'b01, {COEF_FRAC_BITS{1'b0}}};

	// Saturate a one-bit-grown sum back to the delay width
	function automatic logic [DELAY_W-1:0] sat_wide(input logic [DELAY_W:0] s);
		logic [DELAY_W-1:0] r;
		if (s[DELAY_W] != s[DELAY_W-1]) begin
			r = s[DELAY_W] ? D_MIN : D_MAX;
		end else begin
			r = s[DELAY_W-1:0];
		end
		return r;
	endfunction

	function automatic logic [DELAY_W-1:0] sat_add(input logic [DELAY_W-1:0] a,
			input logic [DELAY_W-1:0] b);
		return sat_wide({a[DELAY_W-1], a} + {b[DELAY_W-1], b});
	endfunction

	function automatic logic [DELAY_W-1:0] sat_sub(input logic [DELAY_W-1:0] a,
			input logic [DELAY_W-1:0] b);
		return sat_wide({a[DELAY_W-1], a} - {b[DELAY_W-1], b});
	endfunction

	// Coefficients
	logic [COEF_W-1:0] first_b0_q, first_b1_q, first_a1_q, first_a2_q;
	logic [COEF_W-1:0] second_b0_q, second_b1_q, second_a1_q, second_a2_q;
	// Delay state
	logic [DELAY_W-1:0] first_d1_q, first_d2_q, second_d1_q, second_d2_q;

	// Sequencer and work registers
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   cnt_q;
	logic               sec_q;
	logic               clip_q;
	logic [DELAY_W-1:0] acc_q, tmp_q, bx0_q, bx1_q;
	logic [SAMPLE_WIDTH-1:0] y_q;

	// Output register
	logic                    out_valid_q;
	logic [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                    out_clip_q;

	// Lane hookup
	lane_ctrl_t         lane_ctrl;
	booth_op_t          digit_op;
	logic [COEF_W-1:0]  lane0_coef, lane1_coef;
	logic [DELAY_W-1:0] prod0, prod1;
	logic [SAMPLE_WIDTH-1:0] sreg_x;

	logic in_beat, out_free, cnt_last;

	// Current-section selection
	logic [COEF_W-1:0]  cur_b0, cur_b1, cur_a1, cur_a2;
	logic [DELAY_W-1:0] cur_d1, cur_d2;

	assign cur_b0 = sec_q ? second_b0_q : first_b0_q;
	assign cur_b1 = sec_q ? second_b1_q : first_b1_q;
	assign cur_a1 = sec_q ? second_a1_q : first_a1_q;
	assign cur_a2 = sec_q ? second_a2_q : first_a2_q;
	assign cur_d1 = sec_q ? second_d1_q : first_d1_q;
	assign cur_d2 = sec_q ? second_d2_q : first_d2_q;

	// Rounding and output saturation of a section
	logic [DELAY_W-1:0]      t_rnd;
	logic [SHW-1:0]          y_shift;
	logic                    y_ovf;
	logic [SAMPLE_WIDTH-1:0] y_comb;

	assign t_rnd   = sat_add(acc_q, HALF);
	assign y_shift = t_rnd[DELAY_W-1:COEF_FRAC_BITS];
	assign y_ovf   = !((y_shift[SHW-1:SAMPLE_WIDTH-1] == '0) ||
		(y_shift[SHW-1:SAMPLE_WIDTH-1] == '1));
	assign y_comb  = y_ovf ? (y_shift[SHW-1] ? Y_MIN : Y_MAX)
		: y_shift[SAMPLE_WIDTH-1:0];

	assign in_beat  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign cnt_last = (cnt_q == CNT_W'(NDIG - 1));

	// Digit source and the two multiplier lanes
	bqc_digit_sreg #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_sreg (
		.clk  (clk),
		.load (lane_ctrl.load),
		.step (lane_ctrl.step),
		.x_in (sreg_x),
		.op   (digit_op)
	);

	bqc_booth_lane #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_lane0 (
		.clk  (clk),
		.ctrl (lane_ctrl),
		.op   (digit_op),
		.coef (lane0_coef),
		.prod (prod0)
	);

	bqc_booth_lane #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_lane1 (
		.clk  (clk),
		.ctrl (lane_ctrl),
		.op   (digit_op),
		.coef (lane1_coef),
		.prod (prod1)
	);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and lane control
	always_comb begin
		state_d        = state_q;
		lane_ctrl.load = 1'b0;
		lane_ctrl.step = 1'b0;
		lane0_coef     = cur_b0;
		lane1_coef     = cur_b1;
		sreg_x         = y_q;
		s_axis_tready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				lane0_coef    = first_b0_q;
				lane1_coef    = first_b1_q;
				sreg_x        = s_axis_tdata[SAMPLE_WIDTH-1:0];
				if (s_axis_tvalid) begin
					lane_ctrl.load = 1'b1;
					state_d        = ST_MULX;
				end
			end
			ST_MULX: begin
				lane_ctrl.step = 1'b1;
				if (cnt_last) state_d = ST_ACC;
			end
			ST_ACC: state_d = ST_RND;
			ST_RND: begin
				lane_ctrl.load = 1'b1;
				lane0_coef     = cur_a1;
				lane1_coef     = cur_a2;
				sreg_x         = y_comb;
				state_d        = ST_MULY;
			end
			ST_MULY: begin
				lane_ctrl.step = 1'b1;
				if (cnt_last) state_d = ST_UPD1;
			end
			ST_UPD1: state_d = ST_UPD2;
			ST_UPD2: begin
				if (!sec_q) begin
					lane_ctrl.load = 1'b1;
					lane0_coef     = second_b0_q;
					lane1_coef     = second_b1_q;
					sreg_x         = y_q;
					state_d        = ST_MULX;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Digit counter and section select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sec_q <= 1'b0;
		end else begin
			if ((state_q == ST_MULX || state_q == ST_MULY) && !cnt_last) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
			if (in_beat) begin
				sec_q <= 1'b0;
			end else if (state_q == ST_UPD2) begin
				sec_q <= 1'b1;
			end
		end
	end

	// Section arithmetic: one saturating add per step
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_beat) clip_q <= 1'b0;
			end
			ST_ACC: begin
				acc_q <= sat_add(prod0, cur_d1);
				bx0_q <= prod0;
				bx1_q <= prod1;
			end
			ST_RND: begin
				y_q    <= y_comb;
				clip_q <= clip_q | y_ovf;
			end
			ST_UPD1: tmp_q <= sat_sub(bx1_q, prod0);
			default: ;
		endcase
	end

	// Delay and coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_d1_q  <= '0;
			first_d2_q  <= '0;
			second_d1_q <= '0;
			second_d2_q <= '0;
			first_b0_q  <= COEF_ONE;
			first_b1_q  <= '0;
			first_a1_q  <= '0;
			first_a2_q  <= '0;
			second_b0_q <= COEF_ONE;
			second_b1_q <= '0;
			second_a1_q <= '0;
			second_a2_q <= '0;
		end else begin
			if (state_q == ST_UPD2) begin
				if (sec_q) begin
					second_d1_q <= sat_add(tmp_q, cur_d2);
					second_d2_q <= sat_sub(bx0_q, prod1);
				end else begin
					first_d1_q <= sat_add(tmp_q, cur_d2);
					first_d2_q <= sat_sub(bx0_q, prod1);
				end
			end
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_FIRST_B0:  first_b0_q  <= cfg_data;
					REG_FIRST_B1:  first_b1_q  <= cfg_data;
					REG_FIRST_A1:  first_a1_q  <= cfg_data;
					REG_FIRST_A2:  first_a2_q  <= cfg_data;
					REG_SECOND_B0: second_b0_q <= cfg_data;
					REG_SECOND_B1: second_b1_q <= cfg_data;
					REG_SECOND_A1: second_a1_q <= cfg_data;
					REG_SECOND_A2: second_a2_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign cfg_ready = 1'b1;

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_sample_q <= y_q;
			out_clip_q   <= clip_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_sample_q);
	assign m_axis_tuser  = out_clip_q;

endmodule

`default_nettype wire

>>> design/bqc_checker.sv
// Port-level checks for two_section_biquad_cascade_core, bound to the top
// level. Depends on bqc_pkg and on the top level's ports and SAMPLE_WIDTH.
`timescale 1ns / 1ps
`default_nettype none

module bqc_checker #(
	parameter int SAMPLE_WIDTH = bqc_pkg::SAMPLE_WIDTH_DEF,
	localparam int TDATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata,
	input logic               m_axis_tuser
);

	// No result beat is held once reset has been seen at an edge
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("result beat valid during reset");

	// One sample at a time: input closes after each accepted beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second input beat taken while a sample is in flight");

	// A fresh result cannot appear right after an input beat
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> ##1 !$rose(m_axis_tvalid))
		else $error("result appeared too soon after input beat");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result beat changed");

endmodule

bind two_section_biquad_cascade_core bqc_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_bqc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
